[sv/lfu_pkg.sv]
// Shared widths and request codes for the LFU cache table.
package lfu_pkg;

  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

endpackage

[sv/lfu_if.sv]
// Request and response channel interfaces of the LFU cache table.
interface lfu_req_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

[sv/lfu_cache_table.sv]
// Key/value table with least-frequently-used replacement and LRU tie break.
// Between the acceptance of a request word and its response, one pass reads
// the key, value and count memories one entry per cycle through a single
// compare unit that finds the key match, the eviction victim and a free
// entry, then a drain state empties the read pipeline and an update state
// commits the update and loads the response register. A new request is
// accepted in the cycle after the commit, so a word is only taken once the
// previous one is through, even while the previous response still waits to
// be taken. The commit itself waits as long as an earlier response is still
// held in the response register.
// Capacity writes are taken at any time but must only be made while the table
// is idle.
module lfu_cache_table #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i,
  lfu_req_if.sink                   req_i,
  lfu_rsp_if.source                 rsp_o
);
  import lfu_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_e;

  state_e state_q;

  // Storage: valid bits and recency ranks in flops, the rest in memories.
  logic [ENTRIES-1:0]     valid_q;
  logic [IW-1:0]          rank_q [ENTRIES];
  logic [KEY_W-1:0]       key_mem [ENTRIES];
  logic [VAL_W-1:0]       val_mem [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_mem [ENTRIES];
  logic [FW-1:0]          filled_q;
  logic [CAP_W-1:0]       cap_q;

  // Latched request.
  logic             req_op_q;
  logic [KEY_W-1:0] req_key_q;
  logic [VAL_W-1:0] req_val_q;

  // Scan pipeline.
  logic [IW-1:0]          ptr_q;
  logic                   rd_vld_q;
  logic [IW-1:0]          rd_idx_q;
  logic [KEY_W-1:0]       key_rd_q;
  logic [VAL_W-1:0]       val_rd_q;
  logic [COUNT_WIDTH-1:0] cnt_rd_q;

  // Scan results.
  logic                   match_found_q;
  logic [IW-1:0]          match_idx_q;
  logic [VAL_W-1:0]       match_val_q;
  logic [COUNT_WIDTH-1:0] match_cnt_q;
  logic [IW-1:0]          match_rank_q;
  logic                   vic_found_q;
  logic [IW-1:0]          vic_idx_q;
  logic [COUNT_WIDTH-1:0] vic_cnt_q;
  logic [IW-1:0]          vic_rank_q;
  logic [KEY_W-1:0]       vic_key_q;
  logic                   free_found_q;
  logic [IW-1:0]          free_idx_q;

  // Response register.
  logic             rsp_valid_q;
  logic             rsp_hit_q;
  logic [VAL_W-1:0] rsp_rd_q;
  logic             rsp_ev_q;
  logic [KEY_W-1:0] rsp_evk_q;

  // Compare unit on the entry returning from the memories.
  logic          ent_vld;
  logic [IW-1:0] ent_rank;
  logic          key_eq;
  logic          vic_better;
  logic          free_take;

  always_comb begin
    ent_vld    = valid_q[rd_idx_q];
    ent_rank   = rank_q[rd_idx_q];
    key_eq     = rd_vld_q && ent_vld && (key_rd_q == req_key_q) && !match_found_q;
    vic_better = rd_vld_q && ent_vld &&
                 (!vic_found_q || (cnt_rd_q < vic_cnt_q) ||
                  ((cnt_rd_q == vic_cnt_q) && (ent_rank > vic_rank_q)));
    free_take  = rd_vld_q && !ent_vld && !free_found_q;
  end

  // Update decision.
  logic [CMPW-1:0] eff_cap;
  logic            cap_nz;
  logic            do_evict;
  logic            upd_hit;
  logic            upd_ins;
  logic [IW-1:0]   slot;
  logic            out_free;
  logic            commit;
  logic            touch_all;
  logic [IW-1:0]   touch_idx;
  logic [IW-1:0]   touch_r;

  always_comb begin
    eff_cap   = (CMPW'(cap_q) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(cap_q);
    cap_nz    = (eff_cap != '0);
    do_evict  = (CMPW'(filled_q) >= eff_cap) && vic_found_q;
    upd_hit   = cap_nz && match_found_q;
    upd_ins   = cap_nz && !match_found_q && (req_op_q == OP_PUT) &&
                (do_evict || free_found_q);
    slot      = do_evict ? vic_idx_q : free_idx_q;
    out_free  = !rsp_valid_q || rsp_o.ready;
    commit    = (state_q == ST_UPDATE) && out_free;
    // An eviction followed by an insert shifts ranks exactly like a touch of
    // the victim; a fresh insert ages every valid entry by one.
    touch_all = upd_ins && !do_evict;
    touch_idx = upd_hit ? match_idx_q : slot;
    touch_r   = upd_hit ? match_rank_q : vic_rank_q;
  end

  // Memory write controls.
  logic                   key_we;
  logic                   val_we;
  logic                   cnt_we;
  logic [IW-1:0]          wr_idx;
  logic [COUNT_WIDTH-1:0] cnt_wdata;

  always_comb begin
    key_we    = commit && upd_ins;
    val_we    = commit && ((upd_hit && (req_op_q == OP_PUT)) || upd_ins);
    cnt_we    = commit && ((upd_hit && (match_cnt_q != '1)) || upd_ins);
    wr_idx    = upd_hit ? match_idx_q : slot;
    cnt_wdata = upd_hit ? (match_cnt_q + COUNT_WIDTH'(1)) : COUNT_WIDTH'(1);
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= req_key_q;
    end
    key_rd_q <= key_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_idx] <= req_val_q;
    end
    val_rd_q <= val_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_idx] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cap_q         <= CAP_RESET;
      valid_q       <= '0;
      filled_q      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
      req_op_q      <= OP_GET;
      req_key_q     <= '0;
      req_val_q     <= '0;
      ptr_q         <= '0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      match_val_q   <= '0;
      match_cnt_q   <= '0;
      match_rank_q  <= '0;
      vic_found_q   <= 1'b0;
      vic_idx_q     <= '0;
      vic_cnt_q     <= '0;
      vic_rank_q    <= '0;
      vic_key_q     <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_hit_q     <= 1'b0;
      rsp_rd_q      <= '0;
      rsp_ev_q      <= 1'b0;
      rsp_evk_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (rsp_valid_q && rsp_o.ready && !commit) begin
        rsp_valid_q <= 1'b0;
      end

      rd_vld_q <= (state_q == ST_SCAN);
      rd_idx_q <= ptr_q;

      if (key_eq) begin
        match_found_q <= 1'b1;
        match_idx_q   <= rd_idx_q;
        match_val_q   <= val_rd_q;
        match_cnt_q   <= cnt_rd_q;
        match_rank_q  <= ent_rank;
      end
      if (vic_better) begin
        vic_found_q <= 1'b1;
        vic_idx_q   <= rd_idx_q;
        vic_cnt_q   <= cnt_rd_q;
        vic_rank_q  <= ent_rank;
        vic_key_q   <= key_rd_q;
      end
      if (free_take) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            req_op_q      <= req_i.operation;
            req_key_q     <= req_i.key;
            req_val_q     <= req_i.value;
            ptr_q         <= '0;
            match_found_q <= 1'b0;
            vic_found_q   <= 1'b0;
            free_found_q  <= 1'b0;
            state_q       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ptr_q == IW'(ENTRIES - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            ptr_q <= ptr_q + IW'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            rsp_valid_q <= 1'b1;
            rsp_hit_q   <= upd_hit;
            rsp_rd_q    <= (upd_hit && (req_op_q == OP_GET)) ? match_val_q : '0;
            rsp_ev_q    <= upd_ins && do_evict;
            rsp_evk_q   <= (upd_ins && do_evict) ? vic_key_q : '0;
            if (upd_hit || upd_ins) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (valid_q[i] && (IW'(i) != touch_idx) &&
                    (touch_all || (rank_q[i] < touch_r))) begin
                  rank_q[i] <= rank_q[i] + IW'(1);
                end
              end
              rank_q[touch_idx] <= '0;
            end
            if (upd_ins && !do_evict) begin
              valid_q[slot] <= 1'b1;
              filled_q      <= filled_q + FW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.read_value  = rsp_rd_q;
  assign rsp_o.evicted     = rsp_ev_q;
  assign rsp_o.evicted_key = rsp_evk_q;

  // The fill count always tracks the number of valid entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(filled_q) == $countones(valid_q))
    else $error("fill count disagrees with valid entries");

  // A response never reports both a hit and an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_hit_q && rsp_ev_q))
    else $error("hit and eviction in one response");

  // A nonzero read value only comes with a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_rd_q != '0)) |-> rsp_hit_q)
    else $error("read value without hit");

  // Once the table holds any entry, a full scan always finds a victim.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPDATE) && (valid_q != '0)) |-> vic_found_q)
    else $error("scan missed the eviction victim");

endmodule

[tb/sv/lfu_cache_table_checker.sv]
// Response checker for the LFU cache table: mirrors the table and compares every response word.
`timescale 1ns / 1ps

module lfu_cache_table_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i,
  lfu_req_if                        req_mon,
  lfu_rsp_if                        rsp_mon,
  output int                        fail_count_o,
  output int                        pending_o
);
  import lfu_pkg::*;

  localparam int          NUM_SLOTS = 16;
  localparam logic [15:0] USES_SAT  = 16'hFFFF;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } rsp_word_t;

  logic [CAP_W-1:0] cap_reg;
  logic             slot_used [NUM_SLOTS];
  logic [KEY_W-1:0] slot_key  [NUM_SLOTS];
  logic [VAL_W-1:0] slot_val  [NUM_SLOTS];
  logic [15:0]      slot_uses [NUM_SLOTS];
  int unsigned      slot_age  [NUM_SLOTS];
  int unsigned      used_slots;

  rsp_word_t        awaited_rsp_q[$];
  int               mismatch_cnt;

  assign fail_count_o = mismatch_cnt;

  initial mismatch_cnt = 0;

  function automatic void clear_table();
    cap_reg = CAP_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_uses[i] = '0;
      slot_age[i]  = 0;
    end
    used_slots = 0;
  endfunction

  // Applies one request to the mirrored table and returns the response word it must produce.
  function automatic rsp_word_t lookup_and_update(input logic op, input logic [KEY_W-1:0] k,
                                                  input logic [VAL_W-1:0] v);
    rsp_word_t   r;
    int          eff;
    int          match;
    int          slot;
    int unsigned old_age;
    r = '0;
    eff = (cap_reg > NUM_SLOTS) ? NUM_SLOTS : int'(cap_reg);
    if (eff != 0) begin
      match = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (match < 0 && slot_used[i] && slot_key[i] == k) match = i;
      end
      if (match >= 0) begin
        r.hit = 1'b1;
        if (op == OP_GET) r.read_value = slot_val[match];
        else slot_val[match] = v;
        if (slot_uses[match] != USES_SAT) slot_uses[match] = slot_uses[match] + 16'd1;
        old_age = slot_age[match];
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i] && i != match && slot_age[i] < old_age) slot_age[i]++;
        end
        slot_age[match] = 0;
      end else if (op == OP_PUT) begin
        slot = -1;
        if (used_slots >= eff) begin
          // Lowest use count wins; on a tie the entry touched longest ago goes.
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_used[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
                (slot_uses[i] == slot_uses[slot] && slot_age[i] > slot_age[slot]))) slot = i;
          end
          if (slot >= 0) begin
            r.evicted     = 1'b1;
            r.evicted_key = slot_key[slot];
            slot_used[slot] = 1'b0;
            old_age = slot_age[slot];
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (slot_used[i] && slot_age[i] > old_age) slot_age[i]--;
            end
            if (used_slots > 0) used_slots--;
          end
        end
        if (slot < 0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot < 0 && !slot_used[i]) slot = i;
          end
        end
        if (slot >= 0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_used[i]) slot_age[i]++;
          end
          slot_used[slot] = 1'b1;
          slot_key[slot]  = k;
          slot_val[slot]  = v;
          slot_uses[slot] = 16'd1;
          slot_age[slot]  = 0;
          used_slots++;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_word_t want;
    if (!rst_ni) begin
      clear_table();
      awaited_rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      // The response is taken before the new request is queued, so a stray word
      // can never be matched against a request accepted on the same edge.
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          $error("response word with no request outstanding");
          mismatch_cnt++;
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(rsp_mon.hit));
          check_field("read_value", want.read_value, rsp_mon.read_value);
          check_field("evicted", 32'(want.evicted), 32'(rsp_mon.evicted));
          check_field("evicted_key", want.evicted_key, rsp_mon.evicted_key);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        awaited_rsp_q.push_back(lookup_and_update(req_mon.operation, req_mon.key,
                                                  req_mon.value));
      end
      pending_o <= awaited_rsp_q.size();
    end
  end

endmodule

[tb/sv/lfu_cache_table_test.sv]
// Top of the LFU cache table testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module lfu_cache_table_test;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_MAX    = 24;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  int               mismatch_total;
  int               rsp_pending;
  int               cycle_cnt = 0;
  int               stall_pct;
  int               send_idle_pct;
  logic             hold_toggle;
  logic [KEY_W-1:0] key_pool [POOL_MAX];

  lfu_req_if req_bus ();
  lfu_rsp_if rsp_bus ();

  lfu_cache_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  lfu_cache_table_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_mon      (req_bus),
    .rsp_mon      (rsp_bus),
    .fail_count_o (mismatch_total),
    .pending_o    (rsp_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[lfu_cache_table] ERROR");
      $finish;
    end
  end

  // Response side: random stalls, plus a long hold-off each time hold_toggle flips.
  initial begin : rsp_throttle
    int   hold_left;
    logic seen_toggle;
    hold_left   = 0;
    seen_toggle = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.operation <= op;
    req_bus.key       <= k;
    req_bus.value     <= v;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Drops the request valid and waits until rsp_pending, registered in the checker, is zero.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (rsp_pending != 0);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] c, input int idle, input int stall,
                           input int words, input bit long_hold, input bit mid_pause);
    int               eff;
    int               pool_size;
    int               pick;
    logic [KEY_W-1:0] k;
    set_capacity(c);
    send_idle_pct = idle;
    stall_pct <= stall;
    eff = (c > 16) ? 16 : int'(c);
    pool_size = (eff + 4 > POOL_MAX) ? POOL_MAX : ((eff == 0) ? 8 : eff + 4);
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    for (int n = 0; n < words; n++) begin
      if (long_hold && n == words / 3) hold_toggle <= ~hold_toggle;
      if (mid_pause && n == (2 * words) / 3) wait_drained();
      pick = $urandom_range(99);
      // A hot key builds up a high use count so that frequency, not age, decides evictions.
      if (pick < 20) k = key_pool[0];
      else if (pick < 90) k = key_pool[$urandom_range(pool_size - 1)];
      else k = $urandom;
      send_word(logic'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= CAP_RESET;
    req_bus.valid     <= 1'b0;
    req_bus.operation <= OP_GET;
    req_bus.key       <= '0;
    req_bus.value     <= '0;
    hold_toggle       <= 1'b0;
    stall_pct         <= 0;
    send_idle_pct     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset capacity: miss on an empty table, extreme keys
    // and values, and an update of a present key.
    send_word(OP_GET, 32'h0000_0000, 32'h1111_1111);
    send_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'h0000_0000, 32'h0);
    send_word(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_word(OP_GET, 32'h0000_0000, 32'h0);
    send_word(OP_GET, 32'h1234_5678, 32'h0);
    // Small capacity: evictions by lowest use count.
    set_capacity(5'd2);
    send_word(OP_PUT, 32'h0000_0001, 32'h5A5A_5A5A);
    send_word(OP_PUT, 32'h0000_0002, 32'h0000_0002);
    send_word(OP_GET, 32'h0000_0002, 32'h0);
    send_word(OP_PUT, 32'h0000_0003, 32'h0000_0003);
    // Two entries with equal counts: the older one is the victim.
    set_capacity(5'd3);
    send_word(OP_PUT, 32'h0000_0004, 32'h0000_0004);
    send_word(OP_PUT, 32'h0000_0005, 32'h0000_0005);
    // A disabled cache misses and ignores puts but keeps its entries.
    set_capacity(5'd0);
    send_word(OP_GET, 32'h0000_0000, 32'h0);
    send_word(OP_PUT, 32'h0000_0006, 32'h0000_0006);
    // Capacity above the table size acts as a full table.
    set_capacity(5'd31);
    send_word(OP_GET, 32'h0000_0000, 32'h0);
    send_word(OP_GET, 32'h0000_0006, 32'h0);
    // Capacity below the filled count: each new key evicts and the count holds.
    set_capacity(5'd1);
    send_word(OP_PUT, 32'h0000_0007, 32'h0000_0007);
    send_word(OP_PUT, 32'h0000_0008, 32'h0000_0008);
    send_word(OP_GET, 32'h0000_0008, 32'h0);

    run_phase(5'd16, 0,  0,  95, 1'b0, 1'b0);
    run_phase(5'd4,  69, 0,  95, 1'b0, 1'b0);
    run_phase(5'd1,  0,  69, 95, 1'b0, 1'b0);
    run_phase(5'd31, 7,  7,  95, 1'b0, 1'b0);
    run_phase(5'd0,  0,  0,  40, 1'b0, 1'b0);
    run_phase(5'd8,  0,  0,  95, 1'b1, 1'b0);
    run_phase(CAP_W'($urandom_range(2, 15)), 69, 0, 95, 1'b0, 1'b0);
    run_phase(5'd17, 0,  69, 95, 1'b0, 1'b0);
    run_phase(5'd3,  7,  7,  95, 1'b0, 1'b0);
    run_phase(5'd16, 0,  0,  95, 1'b1, 1'b1);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_total == 0 && rsp_pending == 0) begin
      $display("[lfu_cache_table] OK");
    end else begin
      $display("[lfu_cache_table] ERROR");
    end
    $finish;
  end

endmodule
